[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk with asynchronous reset arst_n, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/uvsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsg_pkg
// types, constants and arithmetic helpers of the uv sphere vertex generator
// ----------------------------------------------------------------------------
package uvsg_pkg;

	localparam int MAX_SEGMENTS = 255;
	localparam logic [7:0] SEG_CAP = 8'((MAX_SEGMENTS < 255) ? MAX_SEGMENTS : 255);
	localparam logic [7:0] MIN_SLICE = 8'd3;
	localparam logic [7:0] MIN_STACK = 8'd2;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SLICE  = 2'd1;
	localparam logic [1:0] REG_STACK  = 2'd2;

	localparam int DIV_STEPS    = 24;
	localparam int CORDIC_STEPS = 18;
	localparam int N_LANES      = 4;
	localparam int LANE_PHI     = 0;
	localparam int LANE_TH      = 1;
	localparam int LANE_U       = 2;
	localparam int LANE_V       = 3;
	localparam int DIV_K [N_LANES] = '{23, 24, 16, 16};

	localparam int CW = 34;
	localparam int ZW = 25;
	localparam int PW = 68;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam int ST_C1    = DIV_STEPS + 1;
	localparam int ST_Q     = ST_C1 + CORDIC_STEPS;
	localparam int ST_M1    = ST_Q + 1;
	localparam int ST_M2    = ST_Q + 2;
	localparam int ST_M3    = ST_Q + 3;
	localparam int ST_OUT   = ST_Q + 4;
	localparam int N_STAGES = ST_OUT + 1;

	typedef enum logic [1:0] {
		CLS_INNER,
		CLS_TOP,
		CLS_BOTTOM,
		CLS_BAD
	} cls_t;

	typedef struct packed {
		logic [7:0]  rem;
		logic [24:0] q;
	} divst_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cst_t;

	typedef struct packed {
		cls_t        cls;
		logic [15:0] vnum;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [1:0]  q_phi;
		logic [1:0]  q_th;
	} side_t;

	function automatic logic [7:0] sat8(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		logic [7:0] r;
		r = v;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		return r;
	endfunction

	// bit of floor(n/2) at position pos of the low dividend field
	function automatic logic div_hbit(logic [7:0] n, int pos);
		logic b;
		b = 1'b0;
		for (int k = 0; k < 7; k++)
			if (k == pos) b = n[k+1];
		return b;
	endfunction

	function automatic divst_t div_step(divst_t s, logic hbit, logic [7:0] n);
		logic [8:0] t;
		logic [8:0] d;
		divst_t r;
		t = {s.rem, hbit};
		d = t - {1'b0, n};
		if (t >= {1'b0, n}) begin
			r.rem = d[7:0];
			r.q = {s.q[23:0], 1'b1};
		end else begin
			r.rem = t[7:0];
			r.q = {s.q[23:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic signed [ZW-1:0] atan_turn(int i);
		logic signed [ZW-1:0] a;
		case (i)
			0:       a = 25'sd2097152;
			1:       a = 25'sd1238021;
			2:       a = 25'sd654136;
			3:       a = 25'sd332050;
			4:       a = 25'sd166669;
			5:       a = 25'sd83416;
			6:       a = 25'sd41718;
			7:       a = 25'sd20860;
			8:       a = 25'sd10430;
			9:       a = 25'sd5215;
			10:      a = 25'sd2608;
			11:      a = 25'sd1304;
			12:      a = 25'sd652;
			13:      a = 25'sd326;
			14:      a = 25'sd163;
			15:      a = 25'sd81;
			16:      a = 25'sd41;
			17:      a = 25'sd20;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic cst_t cordic_step(cst_t s, int i);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		cst_t r;
		dx = $signed(s.y) >>> i;
		dy = $signed(s.x) >>> i;
		if (!s.z[ZW-1]) begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - atan_turn(i);
		end else begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + atan_turn(i);
		end
		return r;
	endfunction

	// round half up, then arithmetic shift
	function automatic logic signed [PW-1:0] rnd_shift(logic signed [PW-1:0] v, int sh);
		logic signed [PW-1:0] h;
		h = '0;
		h[sh-1] = 1'b1;
		return (v + h) >>> sh;
	endfunction

	function automatic logic signed [PW-1:0] clamp_sym(logic signed [PW-1:0] v, int lim);
		logic signed [PW-1:0] l;
		logic signed [PW-1:0] r;
		l = PW'(lim);
		r = v;
		if (v > l) r = l;
		else if (v < -l) r = -l;
		return r;
	endfunction

endpackage

[rtl/uv_sphere_vertex_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top
// one vertex of a uv sphere (index, position, normal, tangent, tex) per
// (ring, slice) pair
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the output is not stalled and gives one
// result per transfer, in order. The pipeline has 25 stages of radix-2
// restoring division for the four phase and texture quotients, 18 stages of
// cordic (both angles side by side), a quadrant stage and four multiply and
// rounding stages, the last of which is the output register.
// Stages stall individually, so bubbles close up while the output waits.
// Registers: 0x0 sphere_radius, 0x4 slice_count, 0x8 stack_count.
`include "assert_macros.svh"

module uv_sphere_vertex_generator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,  // ring_index, slice_index
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vertex_number, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
	// tangent_x, tangent_z, tex_u, tex_v, zero pad
	output logic [183:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser   // status
);
	import uvsg_pkg::*;

	logic [15:0] radius_q;
	logic [7:0]  slice_q;
	logic [7:0]  stack_q;

	logic [N_STAGES-1:0] v_q;
	logic [N_STAGES:0]   en;

	logic [7:0]  ring;
	logic [7:0]  sl;
	cls_t        cls_in;
	logic [7:0]  ring_m1;
	logic [16:0] vbase;
	logic [15:0] vnum_in;
	logic [7:0]  lane_a [N_LANES];
	logic [7:0]  lane_n [N_LANES];
	side_t       side_in;

	divst_t d_st [0:DIV_STEPS][N_LANES];
	side_t  d_side [0:DIV_STEPS];

	cst_t   c_in [2];
	side_t  c_side_in;
	cst_t   c_st [1:CORDIC_STEPS][2];
	side_t  c_side [1:CORDIC_STEPS];

	logic signed [CW-1:0] cp_s43, sp_s43, ct_s43, st_s43;
	side_t                side_s43;

	logic signed [PW-1:0] pnx_s44, pnz_s44, py_s44;
	logic signed [CW-1:0] cp_s44, ct_s44, st_s44;
	side_t                side_s44;

	logic signed [CW-1:0] nx_s45, nz_s45;
	logic [16:0]          posy_s45;
	logic [15:0]          ny_s45, tx_s45, tz_s45;
	side_t                side_s45;

	logic signed [PW-1:0] px_s46, pz_s46;
	logic [15:0]          nxo_s46, nzo_s46;
	logic [16:0]          posy_s46;
	logic [15:0]          ny_s46, tx_s46, tz_s46;
	side_t                side_s46;

	logic [15:0] vnum_s47;
	logic [16:0] px_s47, py_s47, pz_s47;
	logic [15:0] nx_s47, ny_s47, nz_s47, tx_s47, tz_s47;
	logic [16:0] tu_s47, tv_s47;
	logic        status_s47;

	logic signed [16:0] r17;
	logic [16:0] posx_c, posz_c;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd2560;
			slice_q  <= 8'd20;
			stack_q  <= 8'd20;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
				REG_SLICE:  slice_q  <= sat8(pwdata[7:0], MIN_SLICE, SEG_CAP);
				REG_STACK:  stack_q  <= sat8(pwdata[7:0], MIN_STACK, SEG_CAP);
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {16'd0, radius_q};
			REG_SLICE:  prdata = {24'd0, slice_q};
			REG_STACK:  prdata = {24'd0, stack_q};
			default:    prdata = '0;
		endcase
	end

	// stage handshake
	always_comb begin
		en[N_STAGES] = m_axis_tready;
		for (int k = N_STAGES - 1; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = v_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= s_axis_tvalid;
			for (int k = 1; k < N_STAGES; k++)
				if (en[k]) v_q[k] <= v_q[k-1];
		end
	end

	// input classification and divider set-up
	assign ring = s_axis_tdata[7:0];
	assign sl   = s_axis_tdata[15:8];

	always_comb begin
		if (ring > stack_q)        cls_in = CLS_BAD;
		else if (ring == 8'd0)     cls_in = CLS_TOP;
		else if (ring == stack_q)  cls_in = CLS_BOTTOM;
		else if (sl > slice_q)     cls_in = CLS_BAD;
		else                       cls_in = CLS_INNER;
		ring_m1 = ((cls_in == CLS_BOTTOM) ? stack_q : ring) - 8'd1;
		vbase = 17'(ring_m1) * 17'({1'b0, slice_q} + 9'd1);
		case (cls_in)
			CLS_INNER:  vnum_in = 16'(vbase + 17'd1 + 17'(sl));
			CLS_BOTTOM: vnum_in = 16'(vbase + 17'd1);
			default:    vnum_in = 16'd0;
		endcase
		lane_a[LANE_PHI] = ring;
		lane_a[LANE_TH]  = sl;
		lane_a[LANE_U]   = sl;
		lane_a[LANE_V]   = ring;
		lane_n[LANE_PHI] = stack_q;
		lane_n[LANE_TH]  = slice_q;
		lane_n[LANE_U]   = slice_q;
		lane_n[LANE_V]   = stack_q;
		side_in = '0;
		side_in.cls  = cls_in;
		side_in.vnum = vnum_in;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_side[0] <= side_in;
			for (int l = 0; l < N_LANES; l++) begin
				if (lane_a[l] >= lane_n[l]) begin
					d_st[0][l].rem <= lane_a[l] - lane_n[l];
					d_st[0][l].q   <= 25'd1;
				end else begin
					d_st[0][l].rem <= lane_a[l];
					d_st[0][l].q   <= 25'd0;
				end
			end
		end
	end

	// division, one quotient bit per stage
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[j]) begin
				d_side[j] <= d_side[j-1];
				for (int l = 0; l < N_LANES; l++) begin
					if (DIV_K[l] >= j)
						d_st[j][l] <= div_step(d_st[j-1][l],
							div_hbit(lane_n[l], DIV_K[l] - j), lane_n[l]);
					else
						d_st[j][l] <= d_st[j-1][l];
				end
			end
		end
	end

	// cordic, both angles side by side
	always_comb begin
		c_in[0].x = CORDIC_GAIN;
		c_in[0].y = '0;
		c_in[0].z = ZW'(d_st[DIV_STEPS][LANE_PHI].q[21:0]);
		c_in[1].x = CORDIC_GAIN;
		c_in[1].y = '0;
		c_in[1].z = ZW'(d_st[DIV_STEPS][LANE_TH].q[21:0]);
		c_side_in = d_side[DIV_STEPS];
		c_side_in.tex_u = d_st[DIV_STEPS][LANE_U].q[16:0];
		c_side_in.tex_v = d_st[DIV_STEPS][LANE_V].q[16:0];
		c_side_in.q_phi = d_st[DIV_STEPS][LANE_PHI].q[23:22];
		c_side_in.q_th  = d_st[DIV_STEPS][LANE_TH].q[23:22];
	end

	for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
		if (i == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en[DIV_STEPS + i]) begin
					c_side[i] <= c_side_in;
					for (int l = 0; l < 2; l++)
						c_st[i][l] <= cordic_step(c_in[l], i - 1);
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en[DIV_STEPS + i]) begin
					c_side[i] <= c_side[i-1];
					for (int l = 0; l < 2; l++)
						c_st[i][l] <= cordic_step(c_st[i-1][l], i - 1);
				end
			end
		end
	end

	// quadrant
	always_ff @(posedge clk) begin
		if (en[ST_Q]) begin
			side_s43 <= c_side[CORDIC_STEPS];
			case (c_side[CORDIC_STEPS].q_phi)
				2'd0: begin
					cp_s43 <= c_st[CORDIC_STEPS][0].x;
					sp_s43 <= c_st[CORDIC_STEPS][0].y;
				end
				2'd1: begin
					cp_s43 <= -c_st[CORDIC_STEPS][0].y;
					sp_s43 <= c_st[CORDIC_STEPS][0].x;
				end
				2'd2: begin
					cp_s43 <= -c_st[CORDIC_STEPS][0].x;
					sp_s43 <= -c_st[CORDIC_STEPS][0].y;
				end
				default: begin
					cp_s43 <= c_st[CORDIC_STEPS][0].y;
					sp_s43 <= -c_st[CORDIC_STEPS][0].x;
				end
			endcase
			case (c_side[CORDIC_STEPS].q_th)
				2'd0: begin
					ct_s43 <= c_st[CORDIC_STEPS][1].x;
					st_s43 <= c_st[CORDIC_STEPS][1].y;
				end
				2'd1: begin
					ct_s43 <= -c_st[CORDIC_STEPS][1].y;
					st_s43 <= c_st[CORDIC_STEPS][1].x;
				end
				2'd2: begin
					ct_s43 <= -c_st[CORDIC_STEPS][1].x;
					st_s43 <= -c_st[CORDIC_STEPS][1].y;
				end
				default: begin
					ct_s43 <= c_st[CORDIC_STEPS][1].y;
					st_s43 <= -c_st[CORDIC_STEPS][1].x;
				end
			endcase
		end
	end

	assign r17 = $signed({1'b0, radius_q});

	// products of the angle terms, and radius times cos(phi)
	always_ff @(posedge clk) begin
		if (en[ST_M1]) begin
			side_s44 <= side_s43;
			pnx_s44  <= PW'(sp_s43) * PW'(ct_s43);
			pnz_s44  <= PW'(sp_s43) * PW'(st_s43);
			py_s44   <= PW'(r17) * PW'(cp_s43);
			cp_s44   <= cp_s43;
			ct_s44   <= ct_s43;
			st_s44   <= st_s43;
		end
	end

	// rounding of unit vectors and pos_y
	always_ff @(posedge clk) begin
		if (en[ST_M2]) begin
			side_s45 <= side_s44;
			nx_s45   <= CW'(rnd_shift(pnx_s44, 30));
			nz_s45   <= CW'(rnd_shift(pnz_s44, 30));
			posy_s45 <= 17'(clamp_sym(rnd_shift(py_s44, 30), 65535));
			ny_s45   <= 16'(clamp_sym(rnd_shift(PW'(cp_s44), 16), 16384));
			tx_s45   <= 16'(clamp_sym(rnd_shift(-PW'(st_s44), 16), 16384));
			tz_s45   <= 16'(clamp_sym(rnd_shift(PW'(ct_s44), 16), 16384));
		end
	end

	// radius times horizontal normal, and rounding of the horizontal normal
	always_ff @(posedge clk) begin
		if (en[ST_M3]) begin
			side_s46 <= side_s45;
			px_s46   <= PW'(r17) * PW'(nx_s45);
			pz_s46   <= PW'(r17) * PW'(nz_s45);
			nxo_s46  <= 16'(clamp_sym(rnd_shift(PW'(nx_s45), 16), 16384));
			nzo_s46  <= 16'(clamp_sym(rnd_shift(PW'(nz_s45), 16), 16384));
			posy_s46 <= posy_s45;
			ny_s46   <= ny_s45;
			tx_s46   <= tx_s45;
			tz_s46   <= tz_s45;
		end
	end

	assign posx_c = 17'(clamp_sym(rnd_shift(px_s46, 30), 65535));
	assign posz_c = 17'(clamp_sym(rnd_shift(pz_s46, 30), 65535));

	// output register, pole and range cases
	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			vnum_s47   <= side_s46.vnum;
			px_s47     <= '0;
			py_s47     <= '0;
			pz_s47     <= '0;
			nx_s47     <= '0;
			ny_s47     <= '0;
			nz_s47     <= '0;
			tx_s47     <= '0;
			tz_s47     <= '0;
			tu_s47     <= '0;
			tv_s47     <= '0;
			status_s47 <= 1'b0;
			case (side_s46.cls)
				CLS_INNER: begin
					px_s47 <= posx_c;
					py_s47 <= posy_s46;
					pz_s47 <= posz_c;
					nx_s47 <= nxo_s46;
					ny_s47 <= ny_s46;
					nz_s47 <= nzo_s46;
					tx_s47 <= tx_s46;
					tz_s47 <= tz_s46;
					tu_s47 <= side_s46.tex_u;
					tv_s47 <= side_s46.tex_v;
				end
				CLS_TOP: begin
					py_s47 <= {1'b0, radius_q};
					ny_s47 <= 16'sd16384;
					tx_s47 <= 16'sd16384;
				end
				CLS_BOTTOM: begin
					py_s47 <= 17'(-r17);
					ny_s47 <= -16'sd16384;
					tx_s47 <= 16'sd16384;
					tv_s47 <= 17'd65536;
				end
				default: begin
					vnum_s47   <= '0;
					status_s47 <= 1'b1;
				end
			endcase
		end
	end

	assign m_axis_tdata = {3'b000, tv_s47, tu_s47, tz_s47, tx_s47, nz_s47, ny_s47,
		nx_s47, pz_s47, py_s47, px_s47, vnum_s47};
	assign m_axis_tuser = status_s47;

	`AST_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
	`AST_IMPL(a_bad_is_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
	`AST_NEXT(a_ring_beyond_pole, s_axis_tvalid && s_axis_tready && (s_axis_tdata[7:0] > stack_q), d_side[0].cls == CLS_BAD)

endmodule

[verif/uvsg_vertex_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsg_vertex_checker
// watches the vertex generator's register port and streams, predicts every
// vertex from the current register values and compares it field by field
// ----------------------------------------------------------------------------
module uvsg_vertex_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,  // ring_index, slice_index
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [183:0] m_axis_tdata,  // vertex_number .. tex_v, zero pad
	input  logic [0:0]   m_axis_tuser,  // status
	output int           fail_count,
	output int           pending
);
	import uvsg_pkg::*;

	typedef struct {
		logic [183:0] data;
		logic         status;
	} vertex_t;

	vertex_t vertex_q[$];
	logic [15:0] radius;
	logic [7:0]  slices;
	logic [7:0]  stacks;

	localparam longint ATAN_TURNS [18] = '{2097152, 1238021, 654136, 332050, 166669,
		83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

	function automatic longint rshift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint lim(longint v, longint m);
		return (v > m) ? m : ((v < -m) ? -m : v);
	endfunction

	function automatic void phase_sincos(longint phase, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = phase & 64'h3FFFFF;
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURNS[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURNS[i];
			end
		end
		case ((phase >> 22) & 3)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic vertex_t vertex_of(logic [7:0] ring, logic [7:0] sl);
		vertex_t v;
		longint r, pphi, pth, cp, sp, ct, st, nx, nz;
		longint vn, px, py, pz, ny, tx, tz, tu, tv;
		r = radius;
		v.status = 1'b0;
		{vn, px, py, pz, nx, ny, nz, tx, tz, tu, tv} = '0;
		if (ring > stacks) begin
			v.status = 1'b1;
		end else if (ring == 0) begin
			py = r; ny = 16384; tx = 16384;
		end else if (ring == stacks) begin
			vn = 1 + (stacks - 1) * (slices + 1);
			py = -r; ny = -16384; tx = 16384; tv = 65536;
		end else if (sl > slices) begin
			v.status = 1'b1;
		end else begin
			pphi = ((longint'(ring) << 23) + stacks / 2) / stacks;
			pth = (((longint'(sl) << 24) + slices / 2) / slices) & 64'hFFFFFF;
			phase_sincos(pphi, cp, sp);
			phase_sincos(pth, ct, st);
			nx = rshift(sp * ct, 30);
			nz = rshift(sp * st, 30);
			vn = 1 + (ring - 1) * (slices + 1) + sl;
			px = lim(rshift(r * nx, 30), 65535);
			py = lim(rshift(r * cp, 30), 65535);
			pz = lim(rshift(r * nz, 30), 65535);
			nx = lim(rshift(nx, 16), 16384);
			ny = lim(rshift(cp, 16), 16384);
			nz = lim(rshift(nz, 16), 16384);
			tx = lim(rshift(-st, 16), 16384);
			tz = lim(rshift(ct, 16), 16384);
			tu = ((longint'(sl) << 16) + slices / 2) / slices;
			tv = ((longint'(ring) << 16) + stacks / 2) / stacks;
		end
		v.data = {3'd0, tv[16:0], tu[16:0], tz[15:0], tx[15:0], nz[15:0], ny[15:0],
			nx[15:0], pz[16:0], py[16:0], px[16:0], vn[15:0]};
		return v;
	endfunction

	function automatic logic [7:0] clip8(logic [7:0] v, logic [7:0] lo);
		return (v < lo) ? lo : ((v > SEG_CAP) ? SEG_CAP : v);
	endfunction

	assign pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		if (!arst_n) begin
			radius <= 16'd2560;
			slices <= 8'd20;
			stacks <= 8'd20;
			fail_count <= 0;
			vertex_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RADIUS: radius <= (pwdata[15:0] == 0) ? 16'd1 : pwdata[15:0];
					REG_SLICE:  slices <= clip8(pwdata[7:0], MIN_SLICE);
					REG_STACK:  stacks <= clip8(pwdata[7:0], MIN_STACK);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				vertex_q.insert(vertex_q.size(),
					vertex_of(s_axis_tdata[7:0], s_axis_tdata[15:8]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (vertex_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected vertex %h", m_axis_tdata);
				end else begin
					e = vertex_q.pop_front();
					if (e.data !== m_axis_tdata || e.status !== m_axis_tuser[0]) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("vertex mismatch: exp %h/%b got %h/%b",
								e.data, e.status, m_axis_tdata, m_axis_tuser[0]);
					end
				end
			end
		end
	end
endmodule

[verif/tb_uv_sphere_vertex_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator_top
// directed and random (ring, slice) pairs over several sphere settings, with
// random gaps and output stalls, checked by a separate vertex checker
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator_top;
	import uvsg_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [183:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	int           fail_count, pending;
	int           idle_cycles = 0;
	int           sink_wait = 0;
	int           hold_left = 0;
	bit           hold_req = 1'b0;
	bit           hold_done = 1'b0;
	logic [7:0]   cur_slices = 8'd20, cur_stacks = 8'd20;

	always #1 clk = ~clk;

	uv_sphere_vertex_generator_top dut (.*);

	uvsg_vertex_checker checker_i (.*);

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send_vertex(logic [7:0] ring, logic [7:0] sl, bit gaps);
		int gap;
		gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {sl, ring};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] r, logic [7:0] sl, logic [7:0] st);
		drain();
		reg_write(REG_RADIUS, {16'hA5A5, r});
		reg_write(REG_SLICE, {24'h5A5A5A, sl});
		reg_write(REG_STACK, {24'hFFFFFF, st});
		cur_slices = (sl < 3) ? 8'd3 : sl;
		cur_stacks = (st < 2) ? 8'd2 : st;
	endtask

	task automatic random_vertices(int n, bit gaps);
		int k;
		logic [7:0] ring, sl;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			ring = (k == 0) ? 8'($urandom) : 8'($urandom_range(0, cur_stacks));
			sl = (k == 1) ? 8'($urandom) : 8'($urandom_range(0, cur_slices));
			send_vertex(ring, sl, gaps);
		end
	endtask

	// sink: a drawn wait before each transfer, one long hold on request
	always @(posedge clk) begin : p_sink
		int w;
		w = 0;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			if (w == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				sink_wait <= w - 1;
			end
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb_uv_sphere_vertex_generator_top: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed, reset settings
		send_vertex(8'd0, 8'd77, 1'b0);
		send_vertex(8'd20, 8'd255, 1'b0);
		send_vertex(8'd21, 8'd0, 1'b0);
		send_vertex(8'd255, 8'd255, 1'b0);
		send_vertex(8'd1, 8'd0, 1'b0);
		send_vertex(8'd1, 8'd20, 1'b0);
		send_vertex(8'd1, 8'd21, 1'b0);
		send_vertex(8'd10, 8'd5, 1'b0);
		send_vertex(8'd10, 8'd10, 1'b0);
		send_vertex(8'd10, 8'd15, 1'b0);
		send_vertex(8'd19, 8'd255, 1'b0);
		send_vertex(8'd5, 8'd3, 1'b0);
		// long sink hold while offering items
		hold_req = 1'b1;
		random_vertices(80, 1'b0);
		configure(16'hFFFF, 8'd255, 8'd255);
		send_vertex(8'd254, 8'd255, 1'b0);
		send_vertex(8'd255, 8'd0, 1'b0);
		send_vertex(8'd128, 8'd64, 1'b0);
		random_vertices(200, 1'b1);
		configure(16'h0000, 8'd0, 8'd0);
		send_vertex(8'd1, 8'd3, 1'b0);
		send_vertex(8'd2, 8'd0, 1'b0);
		send_vertex(8'd3, 8'd0, 1'b0);
		random_vertices(150, 1'b1);
		configure(16'd1, 8'd3, 8'd2);
		random_vertices(150, 1'b1);
		configure(16'd3000, 8'd37, 8'd91);
		random_vertices(250, 1'b1);
		configure(16'($urandom), 8'($urandom), 8'($urandom));
		random_vertices(300, 1'b1);
		drain();
		if (fail_count == 0)
			$display("tb_uv_sphere_vertex_generator_top: done, clean");
		else
			$display("tb_uv_sphere_vertex_generator_top: done, errors");
		$finish;
	end
endmodule
